FILE: rtl/mbps_pkg.sv
// shared types and constants of the masked byte pattern search unit
`timescale 1ns / 1ps

package mbps_pkg;

  // item actions
  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_DATA = 1'b1;

  // pattern entry kinds, the fourth code behaves as a don't care
  localparam logic [1:0] KIND_EXACT     = 2'd0;
  localparam logic [1:0] KIND_DONT_CARE = 2'd1;
  localparam logic [1:0] KIND_CAPTURE   = 2'd2;

  // configuration registers
  localparam int          REG_PATTERN_LENGTH = 0;
  localparam int          LEN_REG_W          = 6;
  localparam logic [5:0]  LEN_RESET          = 6'd1;

  // capture fields carried by one result
  localparam int CAPTURE_FIELDS = 4;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       action;
    logic [4:0] entry_index;
    logic [1:0] entry_kind;
    logic [7:0] entry_byte;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_offset;
    logic [2:0]  capture_count;
    logic [7:0]  capture_first;
    logic [7:0]  capture_second;
    logic [7:0]  capture_third;
    logic [7:0]  capture_fourth;
  } out_item_t;

  // per byte status handed from front to back
  typedef struct packed {
    logic        last;
    logic        test;
    logic [31:0] offset;
  } item_tag_t;

endpackage

FILE: rtl/mbps_queue.sv
// small register queue between the front and back parts
`timescale 1ns / 1ps

module mbps_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_en,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop_en,
  output logic [WIDTH-1:0]           head_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_en) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_en) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_en && !pop_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_en && pop_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data = mem_r[rd_ptr_r];
  assign count     = count_r;

endmodule

FILE: rtl/mbps_front.sv
// front part: takes items, keeps pattern table and byte window, classifies each window
`timescale 1ns / 1ps

module mbps_front #(
  parameter int MAX_PATTERN = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 item_en,
  input  mbps_pkg::in_item_t                   item,
  input  logic [mbps_pkg::LEN_REG_W-1:0]       pattern_length,
  output logic                                 q_push,
  output mbps_pkg::item_tag_t                  q_tag,
  output logic [MAX_PATTERN-1:0]               q_ok,
  output logic [MAX_PATTERN-1:0]               q_cap,
  output logic [8*MAX_PATTERN-1:0]             q_bytes
);

  import mbps_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int SW = (OFFSET_BITS > LW) ? OFFSET_BITS : LW;

  logic [1:0]             pat_kind_r [MAX_PATTERN];
  logic [7:0]             pat_byte_r [MAX_PATTERN];
  logic [7:0]             window_r   [MAX_PATTERN];
  logic [OFFSET_BITS-1:0] seen_r, seen_nxt;
  logic [OFFSET_BITS-1:0] s1_seen_r;
  logic                   s1_valid_r;
  logic                   s1_last_r;

  logic                   data_en;
  logic [OFFSET_BITS-1:0] seen_inc;
  logic [LW-1:0]          used_len;
  logic [LW-1:0]          start;
  logic [8*MAX_PATTERN-1:0] window_flat;
  logic [8*MAX_PATTERN-1:0] aligned;
  logic [SW-1:0]          diff;

  assign data_en  = item_en && (item.action == ACTION_DATA);
  assign seen_inc = (&seen_r) ? seen_r : seen_r + 1'b1;

  always_comb begin
    seen_nxt = seen_r;
    if (data_en) begin
      seen_nxt = item.last_byte ? '0 : seen_inc;
    end
  end

  // clamp the length register into 1 .. MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      used_len = LW'(1);
    end else if (int'(pattern_length) > MAX_PATTERN) begin
      used_len = LW'(MAX_PATTERN);
    end else begin
      used_len = LW'(pattern_length);
    end
  end

  assign start = LW'(MAX_PATTERN) - used_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      s1_valid_r <= 1'b0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window_r[i] <= '0;
      end
    end else begin
      seen_r     <= seen_nxt;
      s1_valid_r <= data_en;
      if (data_en) begin
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
          window_r[i] <= window_r[i+1];
        end
        window_r[MAX_PATTERN-1] <= item.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_en) begin
      s1_seen_r <= seen_inc;
      s1_last_r <= item.last_byte;
    end
    if (item_en && (item.action == ACTION_LOAD)) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (int'(item.entry_index) == i) begin
          pat_kind_r[i] <= item.entry_kind;
          pat_byte_r[i] <= item.entry_byte;
        end
      end
    end
  end

  // line the window up so that byte j sits under pattern entry j
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      window_flat[8*i +: 8] = window_r[i];
    end
  end

  assign aligned = window_flat >> {start, 3'b000};
  assign diff    = SW'(s1_seen_r) - SW'(used_len);

  always_comb begin
    q_tag.last   = s1_last_r;
    q_tag.test   = SW'(s1_seen_r) >= SW'(used_len);
    q_tag.offset = 32'(diff);
    for (int j = 0; j < MAX_PATTERN; j++) begin
      q_bytes[8*j +: 8] = aligned[8*j +: 8];
      if (j >= int'(used_len)) begin
        q_ok[j]  = 1'b1;
        q_cap[j] = 1'b0;
      end else begin
        q_ok[j]  = (pat_kind_r[j] != KIND_EXACT) || (pat_byte_r[j] == aligned[8*j +: 8]);
        q_cap[j] = (pat_kind_r[j] == KIND_CAPTURE);
      end
    end
  end

  assign q_push = s1_valid_r;

endmodule

FILE: rtl/mbps_back.sv
// back part: match decision, capture selection and the result register
`timescale 1ns / 1ps

module mbps_back #(
  parameter int MAX_PATTERN   = 32,
  parameter int CAPTURE_SLOTS = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  mbps_pkg::item_tag_t       head_tag,
  input  logic [MAX_PATTERN-1:0]    head_ok,
  input  logic [MAX_PATTERN-1:0]    head_cap,
  input  logic [8*MAX_PATTERN-1:0]  head_bytes,
  output logic                      q_pop,
  input  logic                      res_pop,
  output logic                      res_valid,
  output mbps_pkg::out_item_t       res
);

  import mbps_pkg::*;

  localparam int LIMIT = (CAPTURE_SLOTS < CAPTURE_FIELDS) ? CAPTURE_SLOTS : CAPTURE_FIELDS;
  localparam int RW    = $clog2(MAX_PATTERN + 1);

  logic      done_r, done_nxt;
  logic      res_valid_r, res_valid_nxt;
  out_item_t res_r, res_nxt;

  logic          match;
  logic          need_out;
  logic          slot_free;
  logic          take_out;
  logic [RW-1:0] rank [MAX_PATTERN];
  logic [RW-1:0] cap_total;
  logic [2:0]    cap_count;
  logic [7:0]    slot [CAPTURE_FIELDS];

  assign match     = head_tag.test && (&head_ok);
  assign need_out  = !done_r && (match || head_tag.last);
  assign slot_free = !res_valid_r || res_pop;
  assign q_pop     = head_valid && (!need_out || slot_free);
  assign take_out  = q_pop && need_out;

  // rank of each capture entry among the captures before it
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      rank[j] = RW'($countones(head_cap & ~({MAX_PATTERN{1'b1}} << j)));
    end
    cap_total = RW'($countones(head_cap));
    cap_count = (int'(cap_total) > LIMIT) ? 3'(LIMIT) : 3'(cap_total);
    for (int k = 0; k < CAPTURE_FIELDS; k++) begin
      slot[k] = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if ((k < LIMIT) && head_cap[j] && (int'(rank[j]) == k)) begin
          slot[k] = slot[k] | head_bytes[8*j +: 8];
        end
      end
    end
  end

  always_comb begin
    done_nxt      = done_r;
    res_valid_nxt = res_valid_r;
    res_nxt       = res_r;
    if (q_pop) begin
      if (head_tag.last) begin
        done_nxt = 1'b0;
      end else if (!done_r && match) begin
        done_nxt = 1'b1;
      end
    end
    if (take_out) begin
      res_valid_nxt          = 1'b1;
      res_nxt.found          = match;
      res_nxt.match_offset   = match ? head_tag.offset : '0;
      res_nxt.capture_count  = match ? cap_count : '0;
      res_nxt.capture_first  = match ? slot[0] : '0;
      res_nxt.capture_second = match ? slot[1] : '0;
      res_nxt.capture_third  = match ? slot[2] : '0;
      res_nxt.capture_fourth = match ? slot[3] : '0;
    end else if (res_pop) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: rtl/masked_byte_pattern_search_unit.sv
// top level of the masked byte pattern search unit
//
//  channel   direction  transfer when                         payload
//  input     in         push && !full                         in_data  (in_item_t)
//  result    out        pop && !empty                         out_data (out_item_t)
//  config    in/out     psel && penable && pwrite && pready   pwdata / prdata
//
//  one item per cycle sustained while full stays low; a data byte reaches the result
//  register through the window compare into the queue, then the back part
//  the window compare is a barrel alignment of the byte window and one compare per entry
//  rst_n is synchronous and clears control state, the pattern table stays unwritten
//  full rises when the queue plus the compare stage hold QUEUE_DEPTH bytes
//  a waiting result does not block input until that queue fills
`timescale 1ns / 1ps

module masked_byte_pattern_search_unit #(
  parameter int MAX_PATTERN   = 32,
  parameter int CAPTURE_SLOTS = 4,
  parameter int OFFSET_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                push,
  output logic                full,
  input  mbps_pkg::in_item_t  in_data,
  // result channel
  output logic                empty,
  input  logic                pop,
  output mbps_pkg::out_item_t out_data,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import mbps_pkg::*;

  localparam int TAG_W = $bits(item_tag_t);
  localparam int QW    = TAG_W + 2 * MAX_PATTERN + 8 * MAX_PATTERN;
  localparam int QCW   = $clog2(QUEUE_DEPTH + 1);

  // configuration register
  logic [LEN_REG_W-1:0] len_r;
  logic                 cfg_write;

  // front to queue
  logic                     q_push;
  item_tag_t                q_tag;
  logic [MAX_PATTERN-1:0]   q_ok;
  logic [MAX_PATTERN-1:0]   q_cap;
  logic [8*MAX_PATTERN-1:0] q_bytes;
  logic [QW-1:0]            q_wdata;

  // queue to back
  logic [QW-1:0]            q_head;
  logic [QCW-1:0]           q_count;
  logic                     q_pop;
  item_tag_t                h_tag;
  logic [MAX_PATTERN-1:0]   h_ok;
  logic [MAX_PATTERN-1:0]   h_cap;
  logic [8*MAX_PATTERN-1:0] h_bytes;

  logic res_valid;
  logic item_en;

  // apb register access, register index is the word address
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (int'(paddr[2]) == REG_PATTERN_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (cfg_write) begin
      len_r <= pwdata[LEN_REG_W-1:0];
    end
  end

  assign prdata = (int'(paddr[2]) == REG_PATTERN_LENGTH) ? 32'(len_r) : '0;

  // hold off input while the compare stage could overrun the queue
  assign full    = (int'(q_count) + int'(q_push)) >= QUEUE_DEPTH;
  assign item_en = push && !full;

  mbps_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_en        (item_en),
    .item           (in_data),
    .pattern_length (len_r),
    .q_push         (q_push),
    .q_tag          (q_tag),
    .q_ok           (q_ok),
    .q_cap          (q_cap),
    .q_bytes        (q_bytes)
  );

  assign q_wdata = {q_tag, q_ok, q_cap, q_bytes};

  mbps_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (q_push),
    .push_data (q_wdata),
    .pop_en    (q_pop),
    .head_data (q_head),
    .count     (q_count)
  );

  assign {h_tag, h_ok, h_cap, h_bytes} = q_head;

  mbps_back #(
    .MAX_PATTERN   (MAX_PATTERN),
    .CAPTURE_SLOTS (CAPTURE_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_count != '0),
    .head_tag   (h_tag),
    .head_ok    (h_ok),
    .head_cap   (h_cap),
    .head_bytes (h_bytes),
    .q_pop      (q_pop),
    .res_pop    (pop && res_valid),
    .res_valid  (res_valid),
    .res        (out_data)
  );

  assign empty = !res_valid;

endmodule

FILE: rtl/mbps_checker.sv
// port level checks of the masked byte pattern search unit and their bind
`timescale 1ns / 1ps

module mbps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input mbps_pkg::out_item_t out_data
);

  import mbps_pkg::*;

  // reset leaves no result and an open input
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present right after reset");

  a_reset_open: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input full right after reset");

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result changed while waiting");

  // a not found result carries no offset and no captures
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.found) |->
      (out_data.match_offset == 32'd0 && out_data.capture_count == 3'd0))
    else $error("not found result with offset or captures");

  // the fourth capture field is zero when the count is below CAPTURE_FIELDS
  a_capture_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.capture_count < 3'(CAPTURE_FIELDS)) |->
      (out_data.capture_fourth == 8'd0))
    else $error("capture field beyond count is set");

endmodule

bind masked_byte_pattern_search_unit mbps_checker u_mbps_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

FILE: tb/masked_byte_pattern_search_unit_tb.sv
// self-checking testbench of the masked byte pattern search unit
`timescale 1ns / 1ps

module masked_byte_pattern_search_unit_tb;
  import mbps_pkg::*;

  localparam int          TABLE_DEPTH   = 32;
  localparam int          LIMIT_CYCLES  = 400000;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          NO_WRITE      = -1;
  localparam logic [1:0]  KIND_RESERVED = 2'd3;  // fourth kind code, acts as a don't care

  // one row of the directed part: optional length write, the item, a typed result
  typedef struct {
    int        set_len;
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        push     = 1'b0;
  logic        full;
  in_item_t    in_data  = '0;
  logic        empty;
  logic        pop      = 1'b0;
  out_item_t   out_data;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // receiver hold-off for the backpressure phase, and a stretch with no idling
  logic        hold_off = 1'b0;
  bit          hold_go  = 1'b0;
  bit          calm     = 1'b0;

  int          err_count    = 0;
  int          results_seen = 0;
  int          live_items   = 0;
  int          cycles       = 0;

  // search results still owed by the block, oldest first
  out_item_t   pending_reports[$];

  // shadow of the block's state
  logic [1:0]  pt_kind [TABLE_DEPTH];
  logic [7:0]  pt_byte [TABLE_DEPTH];
  logic [7:0]  win     [TABLE_DEPTH];
  logic [31:0] seen;
  bit          run_done;
  logic [5:0]  len_reg;

  masked_byte_pattern_search_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // clamp of the length register as the matcher applies it
  function automatic int used_len();
    if (len_reg == 6'd0) return 1;
    if (len_reg > 6'(TABLE_DEPTH)) return TABLE_DEPTH;
    return int'(len_reg);
  endfunction

  // advance the shadow state by one item; returns 1 when a result is due
  function automatic bit scan_step(input in_item_t it, output out_item_t res);
    int         n;
    int         j;
    int         cnt;
    bit         hit;
    logic [7:0] got;
    logic [7:0] cap [CAPTURE_FIELDS];
    res = '0;
    for (j = 0; j < CAPTURE_FIELDS; j++) cap[j] = 8'h00;
    if (it.action == ACTION_LOAD) begin
      pt_kind[it.entry_index] = it.entry_kind;
      pt_byte[it.entry_index] = it.entry_byte;
      return 1'b0;
    end
    // bytes after a match are dropped, their last flag closes the run
    if (run_done) begin
      if (it.last_byte) begin
        run_done = 1'b0;
        seen     = '0;
      end
      return 1'b0;
    end
    for (j = 0; j < TABLE_DEPTH - 1; j++) win[j] = win[j + 1];
    win[TABLE_DEPTH - 1] = it.data_byte;
    if (seen != 32'hFFFF_FFFF) seen = seen + 32'd1;
    n   = used_len();
    hit = 1'b0;
    cnt = 0;
    if (seen >= 32'(n)) begin
      hit = 1'b1;
      for (j = 0; j < n && hit; j++) begin
        got = win[TABLE_DEPTH - n + j];
        if (pt_kind[j] == KIND_CAPTURE) begin
          if (cnt < CAPTURE_FIELDS) begin
            cap[cnt] = got;
            cnt++;
          end
        end else if (pt_kind[j] == KIND_EXACT && pt_byte[j] != got) begin
          hit = 1'b0;
        end
      end
    end
    if (hit) begin
      res.found          = 1'b1;
      res.match_offset   = seen - 32'(n);
      res.capture_count  = 3'(cnt);
      res.capture_first  = cap[0];
      res.capture_second = cap[1];
      res.capture_third  = cap[2];
      res.capture_fourth = cap[3];
      if (it.last_byte) seen = '0;
      else run_done = 1'b1;
      return 1'b1;
    end
    if (it.last_byte) begin
      seen = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // the fields a load ignores are filled at random, and the same for a data byte
  function automatic in_item_t load_item(int idx, logic [1:0] kind, logic [7:0] val);
    in_item_t it;
    it             = in_item_t'({$urandom, $urandom});
    it.action      = ACTION_LOAD;
    it.entry_index = 5'(idx);
    it.entry_kind  = kind;
    it.entry_byte  = val;
    return it;
  endfunction

  function automatic in_item_t data_item(logic [7:0] val, logic last);
    in_item_t it;
    it           = in_item_t'({$urandom, $urandom});
    it.action    = ACTION_DATA;
    it.data_byte = val;
    it.last_byte = last;
    return it;
  endfunction

  function automatic out_item_t hit_res(int off, int cnt, logic [7:0] c1 = 8'h00,
                                        logic [7:0] c2 = 8'h00);
    out_item_t r;
    r                = '0;
    r.found          = 1'b1;
    r.match_offset   = 32'(off);
    r.capture_count  = 3'(cnt);
    r.capture_first  = c1;
    r.capture_second = c2;
    return r;
  endfunction

  function automatic logic [1:0] rand_kind();
    int r;
    r = $urandom_range(99);
    if (r < 55) return KIND_EXACT;
    if (r < 70) return KIND_DONT_CARE;
    if (r < 90) return KIND_CAPTURE;
    return KIND_RESERVED;
  endfunction

  // offer one item until it transfers, then update the shadow state
  task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t want = '0);
    out_item_t res;
    bit        due;
    if (!calm && $urandom_range(99) < 12) begin
      push <= 1'b0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 40) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    if (it.action == ACTION_LOAD || !run_done) live_items++;
    due = scan_step(it, res);
    if (typed) pending_reports.push_back(want);
    else if (due) pending_reports.push_back(res);
  endtask

  // block idle: every result in, pipeline flushed
  task automatic settle();
    push <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write the pattern length, then read it back
  task automatic cfg_write(input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_PATTERN_LENGTH);
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    len_reg = v[LEN_REG_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[LEN_REG_W-1:0] !== v[LEN_REG_W-1:0]) begin
      $error("pattern_length readback: expected %0d, actual %0d",
             v[LEN_REG_W-1:0], prdata[LEN_REG_W-1:0]);
      err_count++;
    end
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: compare each transfer with the oldest owed result
  always @(posedge clk) begin : result_check
    out_item_t w;
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (pending_reports.size() == 0) begin
        $error("result transfer with no result owed");
        err_count++;
      end else begin
        w = pending_reports.pop_front();
        if (out_data.found !== w.found) begin
          $error("found: expected %0d, actual %0d", w.found, out_data.found);
          err_count++;
        end
        if (out_data.match_offset !== w.match_offset) begin
          $error("match_offset: expected %0d, actual %0d", w.match_offset,
                 out_data.match_offset);
          err_count++;
        end
        if (out_data.capture_count !== w.capture_count) begin
          $error("capture_count: expected %0d, actual %0d", w.capture_count,
                 out_data.capture_count);
          err_count++;
        end
        if (out_data.capture_first !== w.capture_first) begin
          $error("capture_first: expected %h, actual %h", w.capture_first,
                 out_data.capture_first);
          err_count++;
        end
        if (out_data.capture_second !== w.capture_second) begin
          $error("capture_second: expected %h, actual %h", w.capture_second,
                 out_data.capture_second);
          err_count++;
        end
        if (out_data.capture_third !== w.capture_third) begin
          $error("capture_third: expected %h, actual %h", w.capture_third,
                 out_data.capture_third);
          err_count++;
        end
        if (out_data.capture_fourth !== w.capture_fourth) begin
          $error("capture_fourth: expected %h, actual %h", w.capture_fourth,
                 out_data.capture_fourth);
          err_count++;
        end
      end
    end
    pop <= !hold_off && (calm || $urandom_range(99) >= 12);
  end

  // long receiver stall, counted here so the sender keeps offering meanwhile
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("** masked_byte_pattern_search_unit: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t   dir_rows[$];
    int         k;
    int         phase;
    int         n;
    int         runs;
    int         run_len;
    int         s;
    int         c;
    int         r;
    int         b;
    int         j;
    int         new_len;
    bit         plant;
    bit         corrupt;
    logic [7:0] val;

    for (k = 0; k < TABLE_DEPTH; k++) begin
      pt_kind[k] = KIND_EXACT;
      pt_byte[k] = 8'h00;
      win[k]     = 8'h00;
    end
    seen     = '0;
    run_done = 1'b0;
    len_reg  = LEN_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole table first so no unwritten entry is ever compared
    for (k = 0; k < TABLE_DEPTH; k++) send_item(load_item(k, KIND_DONT_CARE, 8'h00));

    // directed part
    dir_rows.push_back('{NO_WRITE, data_item(8'h00, 1'b0), 1'b1, hit_res(0, 0)});
    // byte after a match, its last flag closes the run silently
    dir_rows.push_back('{NO_WRITE, data_item(8'hFF, 1'b1), 1'b0, '0});
    // match on the final byte of a run
    dir_rows.push_back('{NO_WRITE, data_item(8'hAB, 1'b1), 1'b1, hit_res(0, 0)});
    dir_rows.push_back('{NO_WRITE, load_item(0, KIND_CAPTURE, 8'h00), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, data_item(8'h5A, 1'b1), 1'b1, hit_res(0, 1, 8'h5A)});
    dir_rows.push_back('{NO_WRITE, load_item(0, KIND_EXACT, 8'hFF), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, data_item(8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, data_item(8'hFF, 1'b0), 1'b1, hit_res(1, 0)});
    dir_rows.push_back('{NO_WRITE, data_item(8'h12, 1'b1), 1'b0, '0});
    // run ends with no match
    dir_rows.push_back('{NO_WRITE, data_item(8'h00, 1'b1), 1'b1, '0});
    // length zero acts as one
    dir_rows.push_back('{0, data_item(8'hFF, 1'b1), 1'b1, hit_res(0, 0)});
    // length above the table depth is clamped, run too short to test
    dir_rows.push_back('{63, data_item(8'hFF, 1'b1), 1'b1, '0});
    dir_rows.push_back('{4, load_item(1, KIND_CAPTURE, 8'h00), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, load_item(2, KIND_RESERVED, 8'hFF), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, load_item(3, KIND_CAPTURE, 8'h00), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, load_item(31, KIND_EXACT, 8'h00), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, data_item(8'hFF, 1'b0), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, data_item(8'h01, 1'b0), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, data_item(8'h02, 1'b0), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, data_item(8'h03, 1'b1), 1'b1,
                         hit_res(0, 2, 8'h01, 8'h03)});
    // pattern load in the middle of a run
    dir_rows.push_back('{NO_WRITE, data_item(8'hFF, 1'b0), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, data_item(8'h10, 1'b0), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, load_item(1, KIND_EXACT, 8'h10), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, data_item(8'h20, 1'b0), 1'b0, '0});
    dir_rows.push_back('{NO_WRITE, data_item(8'h30, 1'b1), 1'b0, '0});

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_len != NO_WRITE) begin
        settle();
        cfg_write(32'(dir_rows[i].set_len));
      end
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    // random part, one pattern setting per phase
    phase = 0;
    while (live_items < 1500 || results_seen < 48 || phase < 6) begin
      settle();
      calm = (phase == 2);
      if (phase == 4) begin
        // most bytes close a run, so results pile up while the receiver stalls
        cfg_write(32'd1);
        send_item(load_item(0, KIND_DONT_CARE, 8'($urandom)));
        hold_go = 1'b1;
        repeat (48) send_item(data_item(8'($urandom), $urandom_range(99) < 80));
      end else begin
        r = $urandom_range(99);
        if (r < 50)      new_len = $urandom_range(1, 6);
        else if (r < 65) new_len = $urandom_range(7, 16);
        else if (r < 78) new_len = TABLE_DEPTH;
        else if (r < 84) new_len = 0;
        else if (r < 90) new_len = 63;
        else             new_len = $urandom_range(0, 63);
        cfg_write(32'(new_len));
        n = used_len();
        for (k = 0; k < n; k++) send_item(load_item(k, rand_kind(), 8'($urandom)));
        runs = $urandom_range(2, 6);
        repeat (runs) begin
          r = $urandom_range(99);
          if (n > 1 && r < 10) run_len = $urandom_range(1, n - 1);
          else if (r < 16)     run_len = n + $urandom_range(20, 60);
          else                 run_len = n + $urandom_range(0, 12);
          plant   = (run_len >= n) && ($urandom_range(99) < 75);
          s       = plant ? $urandom_range(0, run_len - n) : 0;
          corrupt = plant && ($urandom_range(99) < 20);
          c       = $urandom_range(0, n - 1);
          for (b = 0; b < run_len; b++) begin
            if ($urandom_range(99) < 4)
              send_item(load_item($urandom_range(0, TABLE_DEPTH - 1), rand_kind(),
                                  8'($urandom)));
            val = 8'($urandom);
            if (plant && b >= s && b < s + n) begin
              j = b - s;
              if (pt_kind[j] == KIND_EXACT) begin
                val = pt_byte[j];
                if (corrupt && j == c) val = val ^ 8'($urandom_range(1, 255));
              end
            end else if ($urandom_range(99) < 30) begin
              // near misses built from pattern bytes
              val = pt_byte[$urandom_range(0, n - 1)];
            end
            send_item(data_item(val, b == run_len - 1));
          end
        end
      end
      phase++;
    end

    settle();
    if (err_count == 0) begin
      $display("** masked_byte_pattern_search_unit: PASSED **");
    end else begin
      $display("** masked_byte_pattern_search_unit: FAILED **");
    end
    $finish;
  end

endmodule
